// ===== sv/lfec_pkg.sv =====
package lfec_pkg;

  localparam int SPEED_W = 15;
  localparam int CNT_W   = 16;
  localparam int ERR_W   = 16;
  localparam int MASK_W  = 7;
  localparam int GAIN_W  = 10;
  localparam int PROD_W  = ERR_W + GAIN_W;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_MAX_SPEED    = 3'd0,
    REG_TURN_GAIN    = 3'd1,
    REG_HOLD_TICKS   = 3'd2,
    REG_LOST_SEARCH  = 3'd3,
    REG_SEARCH_BASE  = 3'd4,
    REG_SEARCH_DELTA = 3'd5,
    REG_FAULT_STOP   = 3'd6,
    REG_WIDE_COUNT   = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_NORMAL       = 3'd0,
    MODE_WIDE         = 3'd1,
    MODE_HOLD         = 3'd2,
    MODE_SEARCH_LEFT  = 3'd3,
    MODE_SEARCH_RIGHT = 3'd4,
    MODE_FAULT        = 3'd5,
    MODE_STOPPED      = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_t;

  localparam logic ACT_RUN  = 1'b0;
  localparam logic ACT_STOP = 1'b1;

  typedef struct packed {
    logic [SPEED_W-1:0] max_speed;
    logic [GAIN_W-1:0]  turn_gain;
    logic [CNT_W-1:0]   hold_ticks;
    logic [CNT_W-1:0]   lost_search;
    logic [SPEED_W-1:0] search_base;
    logic [SPEED_W-1:0] search_delta;
    logic [CNT_W-1:0]   fault_stop;
    logic [2:0]         wide_count;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]        lost_cnt;
    logic [CNT_W-1:0]        fault_cnt;
    side_t                   side;
    logic signed [ERR_W-1:0] saved_left;
    logic signed [ERR_W-1:0] saved_right;
    logic                    saved_valid;
  } state_t;

  typedef struct packed {
    logic               ok;
    logic [MASK_W-1:0]  mask;
    logic               err_neg;
    logic               err_nz;
    logic [SPEED_W-1:0] base;
    logic [SPEED_W-1:0] lim;
    logic [PROD_W-1:0]  quo;
  } work_t;

  typedef struct packed {
    logic                    action;
    logic signed [ERR_W-1:0] left;
    logic signed [ERR_W-1:0] right;
    mode_t                   mode;
    logic [CNT_W-1:0]        lost;
    logic [CNT_W-1:0]        fault;
  } result_t;

endpackage

// ===== sv/line_follow_exception_controller_top.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: sample_ok; tdata: sensor_mask, line_error,
//                                   base_speed, turn_limit
// m_*       out  m_tvalid/m_tready  tdata: action, left_speed, right_speed, mode,
//                                   lost_count, fault_count
// cfg_*     in   cfg_wen            cfg_idx selects the register, cfg_wdata is the value
//
// One sample per cycle sustained while m_tready is high. A sample passes through four register
// stages: input, gain multiply, reciprocal multiply for the error scale, result. Sample state
// (counters, last side, saved speeds) updates as a sample enters the result register, so
// back-to-back samples see each other's updates.
// rst (synchronous) empties the pipeline, restores register defaults and clears state.
// A stall on m_tready holds the result register; earlier stages keep filling bubbles.
module line_follow_exception_controller_top #(
  parameter int ERROR_SCALE         = 100,
  parameter bit DEFAULT_SEARCH_LEFT = 1'b1,
  parameter bit STOP_WHEN_LOST      = 1'b1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // sensor_mask, line_error, base_speed, turn_limit, zero pad
  input  logic        s_tuser,   // sample_ok
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // action, left_speed, right_speed, mode, lost_count,
                                 // fault_count, zero pad
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);
  import lfec_pkg::*;

  localparam int SCALE_LOG = $clog2(ERROR_SCALE);
  localparam int SHIFT     = PROD_W + SCALE_LOG;
  localparam int RECIP_W   = PROD_W + 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + longint'(ERROR_SCALE) - 64'd1) / longint'(ERROR_SCALE);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];

  cfg_t cfg;

  logic                    v0;
  logic                    ok0;
  logic [MASK_W-1:0]       mask0;
  logic signed [ERR_W-1:0] err0;
  logic [SPEED_W-1:0]      base0;
  logic [SPEED_W-1:0]      lim0;

  logic                    v1;
  logic                    ok1;
  logic [MASK_W-1:0]       mask1;
  logic                    neg1;
  logic                    nz1;
  logic [SPEED_W-1:0]      base1;
  logic [SPEED_W-1:0]      lim1;
  logic [PROD_W-1:0]       prod1;

  logic                    v2;
  work_t                   w2;

  logic                    v3;
  result_t                 res3;

  state_t                  st;
  state_t                  st_next;
  result_t                 res_next;

  logic                    rdy0;
  logic                    rdy1;
  logic                    rdy2;
  logic                    rdy3;
  logic [ERR_W-1:0]        abs0;
  logic [PROD_W+RECIP_W-1:0] qprod;
  logic [PROD_W+RECIP_W-1:0] qshift;

  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign s_tready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed    <= 15'd2000;
      cfg.turn_gain    <= 10'd100;
      cfg.hold_ticks   <= 16'd10;
      cfg.lost_search  <= 16'd100;
      cfg.search_base  <= 15'd800;
      cfg.search_delta <= 15'd300;
      cfg.fault_stop   <= 16'd5;
      cfg.wide_count   <= 3'd4;
    end else if (cfg_wen) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_MAX_SPEED:    cfg.max_speed    <= cfg_wdata[SPEED_W-1:0];
        REG_TURN_GAIN:    cfg.turn_gain    <= cfg_wdata[GAIN_W-1:0];
        REG_HOLD_TICKS:   cfg.hold_ticks   <= cfg_wdata;
        REG_LOST_SEARCH:  cfg.lost_search  <= cfg_wdata;
        REG_SEARCH_BASE:  cfg.search_base  <= cfg_wdata[SPEED_W-1:0];
        REG_SEARCH_DELTA: cfg.search_delta <= cfg_wdata[SPEED_W-1:0];
        REG_FAULT_STOP:   cfg.fault_stop   <= cfg_wdata;
        REG_WIDE_COUNT:   cfg.wide_count   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && rdy0) begin
      ok0   <= s_tuser;
      mask0 <= s_tdata[6:0];
      err0  <= $signed(s_tdata[22:7]);
      base0 <= s_tdata[37:23];
      lim0  <= s_tdata[52:38];
    end
  end

  assign abs0 = err0[ERR_W-1] ? (~err0 + 1'b1) : err0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (v0 && rdy1) begin
      ok1   <= ok0;
      mask1 <= mask0;
      neg1  <= err0[ERR_W-1];
      nz1   <= (err0 != '0);
      base1 <= base0;
      lim1  <= lim0;
      prod1 <= {{GAIN_W{1'b0}}, abs0} * {{ERR_W{1'b0}}, cfg.turn_gain};
    end
  end

  assign qprod  = {{RECIP_W{1'b0}}, prod1} * {{PROD_W{1'b0}}, RECIP};
  assign qshift = qprod >> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      w2.ok      <= ok1;
      w2.mask    <= mask1;
      w2.err_neg <= neg1;
      w2.err_nz  <= nz1;
      w2.base    <= base1;
      w2.lim     <= lim1;
      w2.quo     <= qshift[PROD_W-1:0];
    end
  end

  lfec_step #(
    .DEFAULT_SEARCH_LEFT (DEFAULT_SEARCH_LEFT),
    .STOP_WHEN_LOST      (STOP_WHEN_LOST)
  ) u_step (
    .cfg     (cfg),
    .st      (st),
    .w       (w2),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      st <= '0;
    end else if (rdy3) begin
      v3 <= v2;
      if (v2) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      res3 <= res_next;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {4'b0000, res3.fault, res3.lost, res3.mode,
                     res3.right, res3.left, res3.action};

`ifndef SYNTHESIS
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res3.action == ACT_STOP) |-> (res3.left == '0 && res3.right == '0))
    else $error("stop with nonzero speed");
  a_fault_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((res3.mode == MODE_FAULT) == (res3.fault != '0)))
    else $error("fault count disagrees with mode");
  a_lost_cnt: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res3.lost != '0) |-> (res3.mode != MODE_NORMAL && res3.mode != MODE_WIDE))
    else $error("lost count nonzero while tracking");
`endif

endmodule

// ===== sv/lfec_step.sv =====
module lfec_step #(
  parameter bit DEFAULT_SEARCH_LEFT = 1'b1,
  parameter bit STOP_WHEN_LOST      = 1'b1
) (
  input  lfec_pkg::cfg_t    cfg,
  input  lfec_pkg::state_t  st,
  input  lfec_pkg::work_t   w,
  output lfec_pkg::state_t  st_next,
  output lfec_pkg::result_t res
);
  import lfec_pkg::*;

  function automatic logic signed [ERR_W-1:0] clamp_spd(
    input logic signed [ERR_W+1:0] v,
    input logic [SPEED_W-1:0]      lim
  );
    logic signed [ERR_W+1:0] pl;
    logic signed [ERR_W+1:0] nl;
    logic signed [ERR_W+1:0] r;
    pl = $signed({3'b000, lim});
    nl = -pl;
    if (v > pl) begin
      r = pl;
    end else if (v < nl) begin
      r = nl;
    end else begin
      r = v;
    end
    return r[ERR_W-1:0];
  endfunction

  logic [2:0]              active;
  logic [CNT_W-1:0]        lost_inc;
  logic [CNT_W-1:0]        fault_inc;
  logic [SPEED_W-1:0]      mag;
  logic signed [ERR_W:0]   corr;
  logic signed [ERR_W+1:0] lsum;
  logic signed [ERR_W+1:0] rsum;
  logic signed [ERR_W-1:0] lcl;
  logic signed [ERR_W-1:0] rcl;
  logic [SPEED_W-1:0]      slow;
  logic [SPEED_W:0]        fast_sum;
  logic [SPEED_W-1:0]      fast;
  logic                    go_left;
  logic [CNT_W:0]          search_end;

  always_comb begin
    active = '0;
    for (int i = 0; i < MASK_W; i++) begin
      active = active + {2'b00, w.mask[i]};
    end
  end

  assign lost_inc  = (st.lost_cnt == CNT_MAX) ? st.lost_cnt : st.lost_cnt + 1'b1;
  assign fault_inc = (st.fault_cnt == CNT_MAX) ? st.fault_cnt : st.fault_cnt + 1'b1;

  assign mag  = (w.quo > {{(PROD_W-SPEED_W){1'b0}}, w.lim}) ? w.lim : w.quo[SPEED_W-1:0];
  assign corr = w.err_neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  assign lsum = $signed({3'b000, w.base}) + {corr[ERR_W], corr};
  assign rsum = $signed({3'b000, w.base}) - {corr[ERR_W], corr};
  assign lcl  = clamp_spd(lsum, cfg.max_speed);
  assign rcl  = clamp_spd(rsum, cfg.max_speed);

  assign slow = (cfg.search_base >= cfg.search_delta) ?
                cfg.search_base - cfg.search_delta : '0;
  assign fast_sum = {1'b0, cfg.search_base} + {1'b0, cfg.search_delta};
  assign fast = (fast_sum > {1'b0, cfg.max_speed}) ? cfg.max_speed : fast_sum[SPEED_W-1:0];
  assign go_left = (st.side == SIDE_LEFT) ? 1'b1 :
                   (st.side == SIDE_RIGHT) ? 1'b0 : DEFAULT_SEARCH_LEFT;
  assign search_end = {1'b0, cfg.hold_ticks} + {1'b0, cfg.lost_search};

  always_comb begin
    st_next    = st;
    res.action = ACT_RUN;
    res.left   = '0;
    res.right  = '0;
    res.mode   = MODE_NORMAL;
    if (!w.ok) begin
      st_next.fault_cnt = fault_inc;
      res.mode = MODE_FAULT;
      if (fault_inc < cfg.fault_stop && st.saved_valid) begin
        res.left  = st.saved_left;
        res.right = st.saved_right;
      end else begin
        res.action = ACT_STOP;
      end
    end else begin
      st_next.fault_cnt = '0;
      if (active == 3'd0) begin
        st_next.lost_cnt = lost_inc;
        if (lost_inc <= cfg.hold_ticks) begin
          res.mode = MODE_HOLD;
          if (st.saved_valid) begin
            res.left  = st.saved_left;
            res.right = st.saved_right;
          end
        end else if ({1'b0, lost_inc} <= search_end || !STOP_WHEN_LOST) begin
          if (go_left) begin
            res.left  = $signed({1'b0, slow});
            res.right = $signed({1'b0, fast});
            res.mode  = MODE_SEARCH_LEFT;
          end else begin
            res.left  = $signed({1'b0, fast});
            res.right = $signed({1'b0, slow});
            res.mode  = MODE_SEARCH_RIGHT;
          end
          st_next.saved_left  = res.left;
          st_next.saved_right = res.right;
          st_next.saved_valid = 1'b1;
        end else begin
          res.mode   = MODE_STOPPED;
          res.action = ACT_STOP;
        end
      end else begin
        st_next.lost_cnt = '0;
        if (w.err_neg) begin
          st_next.side = SIDE_LEFT;
        end else if (w.err_nz) begin
          st_next.side = SIDE_RIGHT;
        end
        res.left  = lcl;
        res.right = rcl;
        st_next.saved_left  = lcl;
        st_next.saved_right = rcl;
        st_next.saved_valid = 1'b1;
        res.mode = (active >= cfg.wide_count) ? MODE_WIDE : MODE_NORMAL;
      end
    end
    res.lost  = st_next.lost_cnt;
    res.fault = st_next.fault_cnt;
  end

endmodule
